/* hw/rtl/life_generation_stencil_defines.svh */
// ============================================================================
// life_generation_stencil_defines.svh
// Assertion macros for the Life generation stencil.
// ============================================================================
`ifndef LIFE_GENERATION_STENCIL_DEFINES_SVH
`define LIFE_GENERATION_STENCIL_DEFINES_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define LGS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds -> consequent holds in the next cycle.
`define LGS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/lgs_pkg.sv */
// ============================================================================
// lgs_pkg
// Grid geometry, field widths and constants of the Life generation stencil.
// ============================================================================
package lgs_pkg;

    localparam int GRID_WIDTH  = 32;
    localparam int GRID_HEIGHT = 32;

    localparam int COL_W   = $clog2(GRID_WIDTH);
    // rows run past the grid by two during the end-of-generation flush
    localparam int ROW_W   = $clog2(GRID_HEIGHT + 2);
    localparam int COUNT_W = 11;
    localparam int LIMIT_W = 8;
    localparam int NBR_W   = 4;
    localparam int HIST_DEPTH = 4;

    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(GRID_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(GRID_HEIGHT - 1);
    localparam logic [ROW_W-1:0] ROW_FLUSH = ROW_W'(GRID_HEIGHT);
    localparam logic [ROW_W-1:0] ROW_END   = ROW_W'(GRID_HEIGHT + 1);

    localparam logic [COUNT_W-1:0] TALLY_MAX   = '1;
    localparam logic [LIMIT_W-1:0] STAG_MAX    = '1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(50);

    localparam logic [NBR_W-1:0] NBR_BIRTH   = NBR_W'(3);
    localparam logic [NBR_W-1:0] NBR_SURVIVE = NBR_W'(2);

    // window column: [2] row above, [1] middle row, [0] row below
    typedef logic [2:0] t_column;

endpackage

/* hw/rtl/life_generation_stencil.sv */
// Order: the result for a cell leaves GRID_WIDTH+1 cells after it; the word that
//   completes its window passes through S1, S2 and the output register to o_out_valid.
// Throughput: one cell per cycle unless the output stalls; after the last cell of a
//   generation the input stalls while the final row and one cell leave the window.
// Reset: synchronous, active low; clears control, tally, history and stagnation counter,
//   limit returns to 50. The line memory is not cleared; edge masking hides its old data.
// ============================================================================
// life_generation_stencil
// Streams one generation of a Game of Life grid in raster order and produces
// the next generation with live count and stagnation-based reseed flag.
// ============================================================================
`include "life_generation_stencil_defines.svh"

module life_generation_stencil (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [lgs_pkg::LIMIT_W-1:0]   i_cfg_wr_data,
    // input words
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_cell_alive,
    // output words
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_next_alive,
    output logic                          o_last_cell,
    output logic [lgs_pkg::COUNT_W-1:0]   o_live_count,
    output logic                          o_reseed_request
);

    // ------------------------------------------------------------------------
    // Line memory: one 2-bit entry per column, {row r-2, row r-1}.
    // A word at column c reads its entry on entry to S1 and writes back
    // {old row r-1, new cell} when it leaves S1 (read-modify-write).
    // Consecutive words differ by one column, so read and write never hit
    // the same entry in one cycle. The one exception is the wrap from the
    // last flush word to the first cell of the next generation, both at
    // column 0; that read gets the old entry, which only holds rows above
    // the grid and is masked.
    // ------------------------------------------------------------------------
    logic [1:0] mem_rows [lgs_pkg::GRID_WIDTH];
    logic [1:0] r_rd;

    // position of the next word to enter (real or flush)
    logic [lgs_pkg::COL_W-1:0] r_col, n_col;
    logic [lgs_pkg::ROW_W-1:0] r_row, n_row;
    logic                      r_flush, n_flush;

    // S1: word waiting for its memory data
    logic                      r_s1_valid;
    logic                      r_s1_cell;
    logic [lgs_pkg::COL_W-1:0] r_s1_col;
    logic [lgs_pkg::ROW_W-1:0] r_s1_row;

    // 3x3 window: column p-2 and column p-1; column p comes from memory
    lgs_pkg::t_column r_win_a;
    lgs_pkg::t_column r_win_b;
    lgs_pkg::t_column new_col;

    // S2: next state of the center cell
    logic r_s2_valid;
    logic r_s2_alive;
    logic r_s2_last;

    // output register
    logic                        r_out_valid;
    logic                        r_out_alive;
    logic                        r_out_last;
    logic [lgs_pkg::COUNT_W-1:0] r_out_count;
    logic                        r_out_reseed;

    // generation statistics
    logic [lgs_pkg::COUNT_W-1:0] r_tally;
    logic [lgs_pkg::COUNT_W-1:0] r_hist [lgs_pkg::HIST_DEPTH];
    logic [lgs_pkg::LIMIT_W-1:0] r_stag;
    logic [lgs_pkg::LIMIT_W-1:0] r_limit;

    // pipeline control
    logic out_load, s2_free, s1_go, s2_go, s1_free, load_s1, in_acc;

    // stencil
    logic                      s1_emit;
    logic                      ctr_first_col, ctr_last_col, ctr_top, ctr_bottom, ctr_last;
    lgs_pkg::t_column          left_m, mid_m, right_m;
    logic [lgs_pkg::NBR_W-1:0] nbr_cnt;
    logic                      nbr_alive;

    // statistics update
    logic [lgs_pkg::COUNT_W-1:0] tally_inc;
    logic                        hist_match;
    logic [lgs_pkg::LIMIT_W-1:0] stag_inc;
    logic                        reseed;

    // ------------------------------------------------------------------------
    // Handshake and stage enables. Each stage moves when the one after it
    // is empty or moving, so bubbles close up and a held output word does
    // not block input until the pipe behind it is full.
    // ------------------------------------------------------------------------
    assign out_load   = !r_out_valid || !i_out_stall;
    assign s2_free    = !r_s2_valid || out_load;
    assign s2_go      = r_s2_valid && out_load;
    assign s1_go      = r_s1_valid && (!s1_emit || s2_free);
    assign s1_free    = !r_s1_valid || s1_go;
    assign o_in_stall = r_flush || !s1_free;
    assign in_acc     = i_in_valid && !o_in_stall;
    // during flush, dead cells of a virtual row enter on their own
    assign load_s1    = s1_free && (r_flush || i_in_valid);

    // ------------------------------------------------------------------------
    // Raster position. After the last real cell, GRID_WIDTH+1 flush words
    // run through the rows below the grid; the last of them sits at column 0
    // two rows past the end and centers the window on the final cell.
    // ------------------------------------------------------------------------
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_flush = r_flush;
        if (load_s1) begin
            if (r_flush && r_col == '0 && r_row == lgs_pkg::ROW_END) begin
                n_col   = '0;
                n_row   = '0;
                n_flush = 1'b0;
            end else begin
                if (r_col == lgs_pkg::COL_LAST) begin
                    n_col = '0;
                    n_row = r_row + lgs_pkg::ROW_W'(1);
                end else begin
                    n_col = r_col + lgs_pkg::COL_W'(1);
                end
                if (!r_flush && r_col == lgs_pkg::COL_LAST && r_row == lgs_pkg::ROW_LAST) begin
                    n_flush = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_flush <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_flush <= n_flush;
        end
    end

    // ------------------------------------------------------------------------
    // Line memory port
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            mem_rows[r_s1_col] <= {r_rd[0], r_s1_cell};
        end
        if (load_s1) begin
            r_rd <= mem_rows[r_col];
        end
    end

    // ------------------------------------------------------------------------
    // S1
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (load_s1) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_s1) begin
            r_s1_cell <= !r_flush && i_cell_alive;
            r_s1_col  <= r_col;
            r_s1_row  <= r_row;
        end
    end

    // Center cell sits one column left and one row up; at column 0 it is the
    // last column of the row two up.
    always_comb begin
        s1_emit       = (r_s1_row >= lgs_pkg::ROW_W'(2)) ||
                        (r_s1_row == lgs_pkg::ROW_W'(1) && r_s1_col != '0);
        ctr_last_col  = (r_s1_col == '0);
        ctr_first_col = (r_s1_col == lgs_pkg::COL_W'(1));
        ctr_top       = ctr_last_col ? (r_s1_row == lgs_pkg::ROW_W'(2))
                                     : (r_s1_row == lgs_pkg::ROW_W'(1));
        ctr_bottom    = ctr_last_col ? (r_s1_row == lgs_pkg::ROW_END)
                                     : (r_s1_row == lgs_pkg::ROW_FLUSH);
        ctr_last      = ctr_last_col && (r_s1_row == lgs_pkg::ROW_END);
    end

    assign new_col = {r_rd[1], r_rd[0], r_s1_cell};

    // mask cells beyond the grid edge; the center itself is not a neighbor
    always_comb begin
        left_m  = ctr_first_col ? '0 : r_win_a;
        right_m = ctr_last_col  ? '0 : new_col;
        mid_m   = {r_win_b[2], 1'b0, r_win_b[0]};
        if (ctr_top) begin
            left_m[2]  = 1'b0;
            right_m[2] = 1'b0;
            mid_m[2]   = 1'b0;
        end
        if (ctr_bottom) begin
            left_m[0]  = 1'b0;
            right_m[0] = 1'b0;
            mid_m[0]   = 1'b0;
        end
        nbr_cnt = '0;
        for (int k = 0; k < 3; k++) begin
            nbr_cnt = nbr_cnt + lgs_pkg::NBR_W'(left_m[k]) + lgs_pkg::NBR_W'(mid_m[k])
                      + lgs_pkg::NBR_W'(right_m[k]);
        end
        nbr_alive = (nbr_cnt == lgs_pkg::NBR_BIRTH) ||
                    (r_win_b[1] && nbr_cnt == lgs_pkg::NBR_SURVIVE);
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_win_a <= r_win_b;
            r_win_b <= new_col;
        end
    end

    // ------------------------------------------------------------------------
    // S2
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_go && s1_emit) begin
            r_s2_valid <= 1'b1;
        end else if (s2_go) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_emit) begin
            r_s2_alive <= nbr_alive;
            r_s2_last  <= ctr_last;
        end
    end

    // ------------------------------------------------------------------------
    // Live tally, history compare and stagnation counter (both saturate)
    // ------------------------------------------------------------------------
    always_comb begin
        tally_inc = (r_s2_alive && r_tally != lgs_pkg::TALLY_MAX)
                  ? r_tally + lgs_pkg::COUNT_W'(1) : r_tally;
        hist_match = 1'b0;
        for (int k = 0; k < lgs_pkg::HIST_DEPTH; k++) begin
            if (r_hist[k] == tally_inc) begin
                hist_match = 1'b1;
            end
        end
        stag_inc = (hist_match && r_stag != lgs_pkg::STAG_MAX)
                 ? r_stag + lgs_pkg::LIMIT_W'(1) : r_stag;
        reseed   = (stag_inc > r_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= '0;
            r_stag  <= '0;
            for (int k = 0; k < lgs_pkg::HIST_DEPTH; k++) begin
                r_hist[k] <= '0;
            end
        end else if (s2_go) begin
            if (r_s2_last) begin
                r_tally <= '0;
                r_stag  <= reseed ? '0 : stag_inc;
                for (int k = lgs_pkg::HIST_DEPTH - 1; k > 0; k--) begin
                    r_hist[k] <= r_hist[k-1];
                end
                r_hist[0] <= tally_inc;
            end else begin
                r_tally <= tally_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= lgs_pkg::LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_out_alive  <= r_s2_alive;
            r_out_last   <= r_s2_last;
            r_out_count  <= r_s2_last ? tally_inc : '0;
            r_out_reseed <= r_s2_last && reseed;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_next_alive     = r_out_alive;
    assign o_last_cell      = r_out_last;
    assign o_live_count     = r_out_count;
    assign o_reseed_request = r_out_reseed;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `LGS_ASSERT_SAME(a_no_rmw_collide, i_clk, i_rst_n, s1_go && load_s1 && r_s1_row != lgs_pkg::ROW_END, r_s1_col != r_col, "line memory read and write hit the same column")
    `LGS_ASSERT_NEXT(a_flush_after_last, i_clk, i_rst_n, in_acc && r_col == lgs_pkg::COL_LAST && r_row == lgs_pkg::ROW_LAST, r_flush && o_in_stall, "flush did not start after the last cell")
    `LGS_ASSERT_SAME(a_stats_only_last, i_clk, i_rst_n, o_out_valid && !o_last_cell, o_live_count == '0 && !o_reseed_request, "statistics on a cell that is not last")
    `LGS_ASSERT_SAME(a_reseed_clears, i_clk, i_rst_n, o_out_valid && o_reseed_request, r_stag == '0, "stagnation counter not cleared on reseed")
    `LGS_ASSERT_SAME(a_tally_restart, i_clk, i_rst_n, o_out_valid && o_last_cell, r_tally == '0, "live tally not restarted after last cell")

endmodule

/* test/life_generation_stencil_tb.sv */
// ============================================================================
// life_generation_stencil_tb
// Streams cells into the stencil from the top of a generation: a full
// block, a live border ring, dead stretches and random fills. The
// stagnation limit is rewritten once the block has drained. A scoreboard
// predicts every output word and checks each one in order.
// ============================================================================
module life_generation_stencil_tb;

    localparam int CELLS         = lgs_pkg::GRID_WIDTH * lgs_pkg::GRID_HEIGHT;
    // cycles without any accepted word before the run is declared hung
    localparam int STUCK_LIMIT   = 2000;
    // pipeline depth plus margin, waited before a limit write and at the end
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic                        next_alive;
        logic                        last_cell;
        logic [lgs_pkg::COUNT_W-1:0] live_count;
        logic                        reseed_request;
    } t_cell_word;

    typedef enum int {
        GEN_DEAD,    // dead cells
        GEN_FULL,    // every cell alive
        GEN_EDGES,   // only the border ring alive
        GEN_SPARSE,  // random, about one cell in eight
        GEN_DENSE    // random, about half
    } t_gen_kind;

    // ------------------------------------------------------------------------
    // Scoreboard: its own copy of the line buffers, tally, history and
    // stagnation counter; predicts output words in raster order.
    // ------------------------------------------------------------------------
    class life_scoreboard;
        logic                        rows [3][lgs_pkg::GRID_WIDTH];
        int                          position;
        logic [lgs_pkg::COUNT_W-1:0] tally;
        logic [lgs_pkg::COUNT_W-1:0] history [lgs_pkg::HIST_DEPTH];
        logic [lgs_pkg::LIMIT_W-1:0] stag;
        logic [lgs_pkg::LIMIT_W-1:0] limit;
        t_cell_word                  due_words [$];
        int                          mismatches;
        int                          words_seen;

        function new();
            foreach (rows[r, c]) rows[r][c] = 1'b0;
            foreach (history[k]) history[k] = '0;
            position   = 0;
            tally      = '0;
            stag       = '0;
            limit      = lgs_pkg::LIMIT_RESET;
            mismatches = 0;
            words_seen = 0;
        endfunction

        function void set_limit(logic [lgs_pkg::LIMIT_W-1:0] v);
            limit = v;
        endfunction

        function int outstanding();
            return due_words.size();
        endfunction

        // cells outside the grid count as dead
        function int count_neighbours(int r, int c);
            int n;
            int rr;
            int cc;
            n = 0;
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    rr = r + dr;
                    cc = c + dc;
                    if (dr == 0 && dc == 0) continue;
                    if (rr < 0 || rr >= lgs_pkg::GRID_HEIGHT ||
                        cc < 0 || cc >= lgs_pkg::GRID_WIDTH) continue;
                    n += rows[rr % 3][cc];
                end
            end
            return n;
        endfunction

        function void resolve_cell(int q);
            int         r;
            int         c;
            int         n;
            logic       self_alive;
            logic       hit;
            t_cell_word w;
            r = q / lgs_pkg::GRID_WIDTH;
            c = q % lgs_pkg::GRID_WIDTH;
            self_alive = rows[r % 3][c];
            n = count_neighbours(r, c);
            w = '0;
            w.next_alive = (!self_alive && n == 3) || (self_alive && (n == 2 || n == 3));
            if (w.next_alive && tally != lgs_pkg::TALLY_MAX) tally++;
            if (q == CELLS - 1) begin
                hit = 1'b0;
                foreach (history[k]) if (history[k] == tally) hit = 1'b1;
                if (hit && stag != lgs_pkg::STAG_MAX) stag++;
                if (stag > limit) begin
                    w.reseed_request = 1'b1;
                    stag = '0;
                end
                for (int k = lgs_pkg::HIST_DEPTH - 1; k > 0; k--) history[k] = history[k-1];
                history[0] = tally;
                w.last_cell  = 1'b1;
                w.live_count = tally;
                tally = '0;
            end
            due_words.push_back(w);
        endfunction

        // one accepted cell; the last cell of a generation flushes the window
        function void note_cell(logic alive);
            rows[(position / lgs_pkg::GRID_WIDTH) % 3][position % lgs_pkg::GRID_WIDTH] = alive;
            if (position == CELLS - 1) begin
                for (int q = position - lgs_pkg::GRID_WIDTH - 1; q < CELLS; q++)
                    resolve_cell(q);
            end else if (position >= lgs_pkg::GRID_WIDTH + 1) begin
                resolve_cell(position - lgs_pkg::GRID_WIDTH - 1);
            end
            position = (position + 1 >= CELLS) ? 0 : position + 1;
        endfunction

        task report(string what, t_cell_word want, t_cell_word got);
            mismatches++;
            $display("word %0d %s: want %0b %0b %0d %0b, got %0b %0b %0d %0b",
                     words_seen, what, want.next_alive, want.last_cell, want.live_count,
                     want.reseed_request, got.next_alive, got.last_cell, got.live_count,
                     got.reseed_request);
        endtask

        task check_word(t_cell_word got);
            t_cell_word want;
            if (due_words.size() == 0) begin
                report("unexpected", '0, got);
                return;
            end
            want = due_words.pop_front();
            if (got.next_alive !== want.next_alive) report("next_alive", want, got);
            if (got.last_cell !== want.last_cell) report("last_cell", want, got);
            if (got.live_count !== want.live_count) report("live_count", want, got);
            if (got.reseed_request !== want.reseed_request) report("reseed_request", want, got);
            words_seen++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic                        i_clk;
    logic                        i_rst_n          = 1'b0;
    logic                        i_cfg_wr_en      = 1'b0;
    logic [lgs_pkg::LIMIT_W-1:0] i_cfg_wr_data    = '0;
    logic                        i_in_valid       = 1'b0;
    logic                        o_in_stall;
    logic                        i_cell_alive     = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_stall      = 1'b0;
    logic                        o_next_alive;
    logic                        o_last_cell;
    logic [lgs_pkg::COUNT_W-1:0] o_live_count;
    logic                        o_reseed_request;

    life_generation_stencil dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cell_alive     (i_cell_alive),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_next_alive     (o_next_alive),
        .o_last_cell      (o_last_cell),
        .o_live_count     (o_live_count),
        .o_reseed_request (o_reseed_request)
    );

    life_scoreboard sb;
    int             idle_pct = 0;   // chance in percent of an idle burst, per word
    int             stuck    = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Output monitor: everything is sampled right at the edge, before any
    // nonblocking update of this step lands.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stuck <= 0;
        end else begin
            if (o_out_valid && !i_out_stall)
                sb.check_word({o_next_alive, o_last_cell, o_live_count, o_reseed_request});
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall))
                stuck <= 0;
            else
                stuck <= stuck + 1;
        end
    end

    initial begin
        while (stuck < STUCK_LIMIT) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    // Receiver back-pressure in random bursts.
    initial begin
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 99) < idle_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            @(posedge i_clk);
        end
    end

    // Offer one cell and hold it until the block takes it. Valid stays high
    // across back-to-back words; it only drops for an idle burst.
    task automatic send_cell(logic alive);
        if ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cell_alive <= alive;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_cell(alive);
    endtask

    // Send a run of cells, continuing from the current raster position.
    task automatic run_cells(t_gen_kind kind, int count, int pct);
        int   row;
        int   col;
        logic alive_bit;
        idle_pct = pct;
        for (int n = 0; n < count; n++) begin
            row = sb.position / lgs_pkg::GRID_WIDTH;
            col = sb.position % lgs_pkg::GRID_WIDTH;
            case (kind)
                GEN_DEAD:   alive_bit = 1'b0;
                GEN_FULL:   alive_bit = 1'b1;
                GEN_EDGES:  alive_bit = (row == 0 || row == lgs_pkg::GRID_HEIGHT - 1 ||
                                         col == 0 || col == lgs_pkg::GRID_WIDTH - 1);
                GEN_SPARSE: alive_bit = ($urandom_range(0, 7) == 0);
                default:    alive_bit = 1'($urandom_range(0, 1));
            endcase
            send_cell(alive_bit);
        end
    endtask

    // Limit writes only land with the block drained: every predicted word
    // has come out and the pipeline has had time to settle.
    task automatic program_limit(logic [lgs_pkg::LIMIT_W-1:0] v);
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_limit(v);
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // a live block over the top edge, then the border ring
        run_cells(GEN_FULL, 40, 0);
        run_cells(GEN_EDGES, 40, 20);
        program_limit(8'd0);
        run_cells(GEN_DENSE, 60, 30);
        run_cells(GEN_DEAD, 20, 10);
        run_cells(GEN_SPARSE, 30, 20);
        // closing stretch with no idling on either side
        run_cells(GEN_DENSE, 40, 0);

        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/lgs_pkg.sv
hw/rtl/life_generation_stencil.sv
test/life_generation_stencil_tb.sv
